>>> rtl/mwmg_pkg.sv
// shared types, codes and helpers for the maze wall merge generator
`timescale 1ns / 1ps

package mwmg_pkg;

  // default grid store size
  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;
  localparam int CELLS_DEF    = MAX_ROWS_DEF * MAX_COLS_DEF;

  // field widths
  localparam int SIZE_W      = 7;
  localparam int CFG_W       = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int LABEL_W     = 8;
  localparam int WALL_W      = 4;
  localparam int OPENED_W    = 2;

  // configuration registers
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS = 1'b1;
  localparam logic [CFG_W-1:0] ROWS_RESET = 5'd10;
  localparam logic [CFG_W-1:0] COLS_RESET = 5'd10;

  // operation codes
  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_PROPOSE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // direction codes
  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_EAST  = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  // wall bit masks
  localparam logic [WALL_W-1:0] WALL_N   = 4'b0001;
  localparam logic [WALL_W-1:0] WALL_S   = 4'b0010;
  localparam logic [WALL_W-1:0] WALL_E   = 4'b0100;
  localparam logic [WALL_W-1:0] WALL_W_M = 4'b1000;
  localparam logic [WALL_W-1:0] WALL_ALL = 4'b1111;

  // input word
  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] direction;
    logic [3:0] row;
    logic [3:0] col;
  } in_word_t;

  // result word
  typedef struct packed {
    logic                merged;
    logic                complete;
    logic [LABEL_W-1:0]  region_label;
    logic                wall_north;
    logic                wall_south;
    logic                wall_east;
    logic                wall_west;
    logic [OPENED_W-1:0] opened_count;
  } out_word_t;

  // read address source
  typedef enum logic [1:0] {
    RD_CELL,
    RD_NBR,
    RD_SWEEP
  } rd_sel_t;

  // kind of pass over the label store
  typedef enum logic [1:0] {
    SW_INIT,
    SW_MERGE,
    SW_CHECK
  } sweep_mode_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        take_item;
    logic        rd_en;
    rd_sel_t     rd_sel;
    logic        own_latch;
    logic        nbr_latch;
    logic        own_update;
    logic        nbr_update;
    logic        sweep_start;
    sweep_mode_t sweep_mode;
    logic        sweep_run;
    logic        load_result;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic legal;
    logic sweep_last;
    logic out_free;
  } dp_stat_t;

  // clamp a size register into 2..maxv
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int maxv);
    logic [SIZE_W-1:0] res;
    if (int'(v) < 2) begin
      res = SIZE_W'(2);
    end else if (int'(v) > maxv) begin
      res = SIZE_W'(maxv);
    end else begin
      res = SIZE_W'(v);
    end
    return res;
  endfunction

  // wall of the originating cell for a direction
  function automatic logic [WALL_W-1:0] own_wall(input logic [1:0] dir);
    logic [WALL_W-1:0] res;
    unique case (dir)
      DIR_NORTH: res = WALL_N;
      DIR_SOUTH: res = WALL_S;
      DIR_EAST:  res = WALL_E;
      DIR_WEST:  res = WALL_W_M;
    endcase
    return res;
  endfunction

  // wall of the neighbor cell for a direction
  function automatic logic [WALL_W-1:0] nbr_wall(input logic [1:0] dir);
    logic [WALL_W-1:0] res;
    unique case (dir)
      DIR_NORTH: res = WALL_S;
      DIR_SOUTH: res = WALL_N;
      DIR_EAST:  res = WALL_W_M;
      DIR_WEST:  res = WALL_E;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/mwmg_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mwmg_ram import mwmg_pkg::*; #(
  parameter int WIDTH = LABEL_W,
  parameter int DEPTH = CELLS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/mwmg_dp.sv
// datapath: cell stores, neighbor checks, label sweep and result register
`timescale 1ns / 1ps

module mwmg_dp import mwmg_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  in_word_t               cmd_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output out_word_t              res_data,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat
);

  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int AW        = $clog2(CELLS);
  localparam int RCW       = $clog2(MAX_ROWS);
  localparam int CCW       = $clog2(MAX_COLS);
  localparam int LAST_CELL = CELLS - 1;

  logic [CFG_W-1:0]    rows_cfg;
  logic [CFG_W-1:0]    cols_cfg;
  logic [SIZE_W-1:0]   eff_rows;
  logic [SIZE_W-1:0]   eff_cols;
  in_word_t            item;
  logic [SIZE_W-1:0]   row_w;
  logic [SIZE_W-1:0]   col_w;
  logic [SIZE_W-1:0]   nbr_row;
  logic [SIZE_W-1:0]   nbr_col;
  logic                base_ok;
  logic                dir_ok;
  logic [OPENED_W-1:0] limit;
  logic                in_store;
  logic [AW-1:0]       cell_addr;
  logic [AW-1:0]       nbr_addr;
  logic [AW-1:0]       raddr;
  logic [LABEL_W-1:0]  lab_rd;
  logic [WALL_W-1:0]   wall_rd;
  logic [OPENED_W-1:0] opn_rd;
  logic [LABEL_W-1:0]  own_label;
  logic [WALL_W-1:0]   own_walls;
  logic [OPENED_W-1:0] own_opened;
  logic [LABEL_W-1:0]  nbr_label;
  logic [WALL_W-1:0]   nbr_walls;
  logic                merged;
  sweep_mode_t         sw_mode;
  logic                sw_issue;
  logic [AW-1:0]       sw_addr;
  logic [RCW-1:0]      sw_row;
  logic [CCW-1:0]      sw_col;
  logic                pk_valid;
  logic                pk_last;
  logic [AW-1:0]       pk_addr;
  logic [RCW-1:0]      pk_row;
  logic [CCW-1:0]      pk_col;
  logic [LABEL_W-1:0]  lab_cnt;
  logic [LABEL_W-1:0]  first_label;
  logic                all_same;
  logic                pk_act;
  logic                pk_in_grid;
  logic                lab_match;
  logic [LABEL_W-1:0]  new_label;
  logic                lab_we;
  logic                init_we;
  logic                wall_we;
  logic [AW-1:0]       wall_waddr;
  logic [WALL_W-1:0]   wall_wdata;
  logic                opn_we;
  logic [AW-1:0]       opn_waddr;
  logic [OPENED_W-1:0] opn_wdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS: rows_cfg <= cfg_data;
        REG_COLS: cols_cfg <= cfg_data;
      endcase
    end
  end

  assign eff_rows = clamp_size(rows_cfg, MAX_ROWS);
  assign eff_cols = clamp_size(cols_cfg, MAX_COLS);

  // accepted word
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item <= cmd_data;
    end
  end

  // neighbor position and geometry checks
  assign row_w   = SIZE_W'(item.row);
  assign col_w   = SIZE_W'(item.col);
  assign base_ok = (row_w < eff_rows) && (col_w < eff_cols);

  always_comb begin
    nbr_row = row_w;
    nbr_col = col_w;
    dir_ok  = 1'b0;
    limit   = '0;
    unique case (item.direction)
      DIR_NORTH: begin
        dir_ok  = (row_w != '0);
        nbr_row = row_w - SIZE_W'(1);
        limit   = OPENED_W'(1);
      end
      DIR_SOUTH: begin
        dir_ok  = ((row_w + SIZE_W'(1)) < eff_rows);
        nbr_row = row_w + SIZE_W'(1);
      end
      DIR_EAST: begin
        dir_ok  = ((col_w + SIZE_W'(1)) < eff_cols);
        nbr_col = col_w + SIZE_W'(1);
      end
      DIR_WEST: begin
        dir_ok  = (col_w != '0);
        nbr_col = col_w - SIZE_W'(1);
        limit   = OPENED_W'(1);
      end
    endcase
  end

  assign cell_addr = AW'(int'(item.row) * MAX_COLS + int'(item.col));
  assign nbr_addr  = AW'(int'(nbr_row) * MAX_COLS + int'(nbr_col));
  assign in_store  = (int'(item.row) < MAX_ROWS) && (int'(item.col) < MAX_COLS);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_CELL:  raddr = cell_addr;
      RD_NBR:   raddr = nbr_addr;
      RD_SWEEP: raddr = sw_addr;
      default:  raddr = cell_addr;
    endcase
  end

  // originating and neighbor cell latches
  always_ff @(posedge clk) begin
    if (cmd.own_latch) begin
      own_label  <= lab_rd;
      own_walls  <= wall_rd;
      own_opened <= opn_rd;
    end
    if (cmd.nbr_latch) begin
      nbr_label <= lab_rd;
      nbr_walls <= wall_rd;
    end
  end

  // merge legality, neighbor label straight from the label store
  assign stat.legal = base_ok && dir_ok && (own_opened <= limit) && (own_label != lab_rd);

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      merged <= 1'b0;
    end else if (cmd.own_update) begin
      merged <= 1'b1;
    end
  end

  // sweep: per cell label rewrite and single label check
  assign pk_act     = cmd.sweep_run && pk_valid;
  assign pk_in_grid = (SIZE_W'(pk_row) < eff_rows) && (SIZE_W'(pk_col) < eff_cols);
  assign lab_match  = pk_in_grid && (lab_rd == own_label);

  always_comb begin
    case (sw_mode)
      SW_INIT:  new_label = pk_in_grid ? lab_cnt : '0;
      SW_MERGE: new_label = lab_match ? nbr_label : lab_rd;
      default:  new_label = lab_rd;
    endcase
  end

  assign init_we = pk_act && (sw_mode == SW_INIT);
  assign lab_we  = init_we || (pk_act && (sw_mode == SW_MERGE) && lab_match);

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_issue <= 1'b0;
      pk_valid <= 1'b0;
    end else if (cmd.sweep_start) begin
      sw_issue <= 1'b1;
      pk_valid <= 1'b0;
    end else if (cmd.sweep_run) begin
      if (sw_addr == AW'(LAST_CELL)) begin
        sw_issue <= 1'b0;
      end
      pk_valid <= sw_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      sw_mode  <= cmd.sweep_mode;
      sw_addr  <= '0;
      sw_row   <= '0;
      sw_col   <= '0;
      lab_cnt  <= '0;
      all_same <= 1'b1;
    end else if (cmd.sweep_run) begin
      // issue side
      if (sw_issue) begin
        sw_addr <= sw_addr + AW'(1);
        if (sw_col == CCW'(MAX_COLS - 1)) begin
          sw_col <= '0;
          sw_row <= sw_row + RCW'(1);
        end else begin
          sw_col <= sw_col + CCW'(1);
        end
      end
      pk_addr <= sw_addr;
      pk_row  <= sw_row;
      pk_col  <= sw_col;
      pk_last <= (sw_addr == AW'(LAST_CELL));
      // data side
      if (pk_valid) begin
        if ((sw_mode == SW_INIT) && pk_in_grid) begin
          lab_cnt <= lab_cnt + LABEL_W'(1);
        end
        if (pk_addr == '0) begin
          first_label <= new_label;
        end else if (pk_in_grid && (new_label != first_label)) begin
          all_same <= 1'b0;
        end
      end
    end
  end

  assign stat.sweep_last = pk_valid && pk_last;

  // wall store write select
  always_comb begin
    if (cmd.own_update) begin
      wall_waddr = cell_addr;
      wall_wdata = own_walls & ~own_wall(item.direction);
    end else if (cmd.nbr_update) begin
      wall_waddr = nbr_addr;
      wall_wdata = nbr_walls & ~nbr_wall(item.direction);
    end else begin
      wall_waddr = pk_addr;
      wall_wdata = WALL_ALL;
    end
  end

  assign wall_we = cmd.own_update || cmd.nbr_update || init_we;

  // opened count write select
  assign opn_we    = cmd.own_update || init_we;
  assign opn_waddr = cmd.own_update ? cell_addr : pk_addr;
  assign opn_wdata = cmd.own_update ? (own_opened + OPENED_W'(1)) : '0;

  // cell stores
  mwmg_ram #(.WIDTH(LABEL_W), .DEPTH(CELLS)) u_label_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (pk_addr),
    .wdata (new_label),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (lab_rd)
  );

  mwmg_ram #(.WIDTH(WALL_W), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (wall_rd)
  );

  mwmg_ram #(.WIDTH(OPENED_W), .DEPTH(CELLS)) u_opened_ram (
    .clk   (clk),
    .we    (opn_we),
    .waddr (opn_waddr),
    .wdata (opn_wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (opn_rd)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_data.merged       <= merged;
      res_data.complete     <= all_same;
      res_data.region_label <= in_store ? lab_rd : '0;
      res_data.wall_north   <= in_store && wall_rd[0];
      res_data.wall_south   <= in_store && wall_rd[1];
      res_data.wall_east    <= in_store && wall_rd[2];
      res_data.wall_west    <= in_store && wall_rd[3];
      res_data.opened_count <= in_store ? opn_rd : '0;
    end
  end

  assign stat.out_free = !res_valid || res_ready;

endmodule

>>> rtl/mwmg_ctrl.sv
// controller state machine sequencing reads, updates and label sweeps
`timescale 1ns / 1ps

module mwmg_ctrl import mwmg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  logic [1:0] op,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_START,
    S_CLEAR,
    S_IDLE,
    S_OWN_RD,
    S_NBR_RD,
    S_DECIDE,
    S_WR_NBR,
    S_SWEEP,
    S_RES_RD,
    S_RES_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_START;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_START: begin
        cmd.sweep_start = 1'b1;
        cmd.sweep_mode  = SW_INIT;
        state_next      = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.sweep_run = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.take_item = 1'b1;
          unique case (op)
            OP_INIT: begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_mode  = SW_INIT;
              state_next      = S_SWEEP;
            end
            OP_PROPOSE: begin
              state_next = S_OWN_RD;
            end
            default: begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_mode  = SW_CHECK;
              state_next      = S_SWEEP;
            end
          endcase
        end
      end
      S_OWN_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CELL;
        state_next = S_NBR_RD;
      end
      S_NBR_RD: begin
        cmd.own_latch = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_NBR;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.nbr_latch = 1'b1;
        if (stat.legal) begin
          cmd.own_update = 1'b1;
          state_next     = S_WR_NBR;
        end else begin
          cmd.sweep_start = 1'b1;
          cmd.sweep_mode  = SW_CHECK;
          state_next      = S_SWEEP;
        end
      end
      S_WR_NBR: begin
        cmd.nbr_update  = 1'b1;
        cmd.sweep_start = 1'b1;
        cmd.sweep_mode  = SW_MERGE;
        state_next      = S_SWEEP;
      end
      S_SWEEP: begin
        cmd.sweep_run = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_SWEEP;
        if (stat.sweep_last) begin
          state_next = S_RES_RD;
        end
      end
      S_RES_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_CELL;
        state_next = S_RES_OUT;
      end
      S_RES_OUT: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_START;
      end
    endcase
  end

endmodule

>>> rtl/maze_wall_merge_generator_unit.sv
// top level of the maze wall merge generator
`timescale 1ns / 1ps

// Grid maze builder that joins regions by label. Each word is an init, a
// wall removal proposal or a read, and gives exactly one result word. Every
// word makes one pass over the label store, one cell per clock, over all
// MAX_ROWS*MAX_COLS cells; a proposal first reads the cell and its neighbor
// and, when it merges, writes the walls of both cells. The result sits in an
// output register, so the next word is taken while a result still waits; a
// word whose result finds the previous one still waiting holds until that one
// is taken. After reset the block runs a clearing pass with cmd_ready low
// that sets up the 10 by 10 grid; configuration writes are taken at any time
// the block is idle.

module maze_wall_merge_generator_unit import mwmg_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  in_word_t               cmd_data,
  output logic                   res_valid,
  input  logic                   res_ready,
  output out_word_t              res_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  mwmg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .op        (cmd_data.operation),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // stores and datapath
  mwmg_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

endmodule
